FILE: design/i2cmbe_pkg.sv
package i2cmbe_pkg;

    // Input item kinds
    typedef enum logic [2:0] {
        KIND_TICK      = 3'd0,
        KIND_START     = 3'd1,
        KIND_STOP      = 3'd2,
        KIND_WRITE     = 3'd3,
        KIND_READ_ACK  = 3'd4,
        KIND_READ_BYTE = 3'd5,
        KIND_SEND_ACK  = 3'd6,
        KIND_PROBE     = 3'd7
    } kind_t;

    // Line sequencer phases
    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_ST0  = 5'd1,
        PH_ST1  = 5'd2,
        PH_SP0  = 5'd3,
        PH_SP1  = 5'd4,
        PH_SP2  = 5'd5,
        PH_WB0  = 5'd6,
        PH_WB1  = 5'd7,
        PH_WB2  = 5'd8,
        PH_AK0  = 5'd9,
        PH_AK1  = 5'd10,
        PH_AK2  = 5'd11,
        PH_RB0  = 5'd12,
        PH_RB1  = 5'd13,
        PH_RB2  = 5'd14,
        PH_SA0  = 5'd15,
        PH_SA1  = 5'd16,
        PH_SA2  = 5'd17
    } phase_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_BIT_PHASE = 2'd0;
    localparam logic [1:0] CFG_HOLD      = 2'd1;
    localparam logic [1:0] CFG_ACK_WAIT  = 2'd2;

    localparam logic [7:0] BIT_PHASE_RESET = 8'd5;
    localparam logic [7:0] HOLD_RESET      = 8'd8;
    localparam logic [9:0] ACK_WAIT_RESET  = 10'd250;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       sda_level;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_out;
        logic       sda_drive;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       got_nack;
        logic       timed_out;
        logic       rejected;
    } out_item_t;

    typedef struct packed {
        logic [7:0] bit_phase_ticks;
        logic [7:0] hold_ticks;
        logic [9:0] ack_wait_limit;
    } cfg_t;

    // Classified item as it sits in the command queue
    typedef struct packed {
        logic       is_cmd;
        kind_t      kind;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       sda_level;
    } q_entry_t;

    typedef struct packed {
        logic scl;
        logic sda;
        logic drv;
    } lines_t;

endpackage

FILE: design/i2c_master_bit_engine.sv
// I2C master line sequencer.
// s_* channel (valid/ready): one transaction per tick or command. A tick carries
//   the sampled SDA level and advances the sequencer one step; a command
//   (start, stop, write, read ack, read byte, send ack, probe) starts a sequence.
// m_* channel (valid/ready): exactly one result per input transaction, in order:
//   SCL/SDA line settings, done flag, received byte, ack status, reject flag.
// cfg_we/cfg_index/cfg_wdata: write-only timing registers (0 bit phase ticks,
//   1 start/stop/ack hold ticks, 2 ack wait limit). Write only while idle.
// Path: the front classifies an accepted transaction into the queue; the
//   sequencer then executes it into the result register that drives m_*.
// Throughput: one transaction per clock while the receiver takes results, with
//   one sequencer step per transaction and the 2-entry queue between front and sequencer.
// Receiver stall: the result register holds; the queue fills, then s_ready
//   drops until the receiver takes a result.
// Reset (aresetn low, synchronous): sequencer idle, SCL high, SDA high and
//   driven, status cleared, timing registers back to 5 / 8 / 250.
module i2c_master_bit_engine import i2cmbe_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [9:0] cfg_wdata
);

    cfg_t     cfg_reg;
    logic     q_full, push, pop, q_valid;
    q_entry_t push_data, q_data;

    // Timing registers; index 3 is unused and ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bit_phase_ticks <= BIT_PHASE_RESET;
            cfg_reg.hold_ticks      <= HOLD_RESET;
            cfg_reg.ack_wait_limit  <= ACK_WAIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_BIT_PHASE: cfg_reg.bit_phase_ticks <= cfg_wdata[7:0];
                CFG_HOLD:      cfg_reg.hold_ticks      <= cfg_wdata[7:0];
                CFG_ACK_WAIT:  cfg_reg.ack_wait_limit  <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // Front: accept and classify
    i2cmbe_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // Short queue so front and sequencer stall independently
    i2cmbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    // Back: line sequencer plus result register
    i2cmbe_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: design/i2cmbe_front.sv
module i2cmbe_front import i2cmbe_pkg::*; (
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     q_full,
    output logic     push,
    output q_entry_t push_data
);

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    // Ticks only carry the SDA sample; commands carry byte and ack level.
    always_comb begin
        push_data.is_cmd    = (s_data.kind != KIND_TICK);
        push_data.kind      = s_data.kind;
        push_data.tx_byte   = push_data.is_cmd ? s_data.tx_byte : 8'd0;
        push_data.send_nack = push_data.is_cmd ? s_data.send_nack : 1'b0;
        push_data.sda_level = push_data.is_cmd ? 1'b1 : s_data.sda_level;
    end

endmodule

FILE: design/i2cmbe_queue.sv
module i2cmbe_queue import i2cmbe_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     q_valid,
    output q_entry_t q_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    q_entry_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/i2cmbe_back.sv
module i2cmbe_back import i2cmbe_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      q_valid,
    input  q_entry_t  q_data,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    phase_t     phase_reg, phase_next;
    kind_t      active_reg, active_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] tick_count_reg, tick_count_next;
    logic [9:0] wait_count_reg, wait_count_next;
    lines_t     lines_reg, lines_next;
    logic [1:0] status_reg, status_next;
    logic       m_valid_reg;
    out_item_t  m_data_reg, m_data_next;

    logic       fire;
    logic       do_enter, do_finish, do_reject, do_start;
    logic       do_timeout, do_wait_inc, do_tick_inc;
    logic       do_shift_wr, do_shift_rd, do_bc_inc, do_bc_clr;
    logic [7:0] len_sel, step_len;
    logic       reach;
    logic [3:0] bc_inc;
    logic       byte_done;

    function automatic lines_t lines_of(phase_t p, logic [7:0] sh);
        lines_t l;
        l = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
        case (p)
            PH_ST0:  l = '{scl: 1'b1, sda: 1'b1,  drv: 1'b1};
            PH_ST1:  l = '{scl: 1'b1, sda: 1'b0,  drv: 1'b1};
            PH_SP0:  l = '{scl: 1'b0, sda: 1'b0,  drv: 1'b1};
            PH_SP1:  l = '{scl: 1'b1, sda: 1'b0,  drv: 1'b1};
            PH_SP2:  l = '{scl: 1'b1, sda: 1'b1,  drv: 1'b1};
            PH_WB0:  l = '{scl: 1'b0, sda: sh[7], drv: 1'b1};
            PH_WB1:  l = '{scl: 1'b1, sda: sh[7], drv: 1'b1};
            PH_WB2:  l = '{scl: 1'b0, sda: sh[7], drv: 1'b1};
            PH_AK0:  l = '{scl: 1'b0, sda: 1'b1,  drv: 1'b0};
            PH_AK1:  l = '{scl: 1'b1, sda: 1'b1,  drv: 1'b0};
            PH_AK2:  l = '{scl: 1'b1, sda: 1'b1,  drv: 1'b0};
            PH_RB0:  l = '{scl: 1'b0, sda: 1'b1,  drv: 1'b0};
            PH_RB1:  l = '{scl: 1'b1, sda: 1'b1,  drv: 1'b0};
            PH_RB2:  l = '{scl: 1'b0, sda: 1'b1,  drv: 1'b0};
            PH_SA0:  l = '{scl: 1'b0, sda: sh[0], drv: 1'b1};
            PH_SA1:  l = '{scl: 1'b1, sda: sh[0], drv: 1'b1};
            PH_SA2:  l = '{scl: 1'b0, sda: sh[0], drv: 1'b1};
            default: l = '{scl: 1'b1, sda: 1'b1,  drv: 1'b1};
        endcase
        return l;
    endfunction

    // One queued transaction per cycle whenever the output slot frees up
    assign fire    = q_valid && (!m_valid_reg || m_ready);
    assign pop     = fire;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Data bit phases use the bit timing, everything else the hold timing
    assign len_sel = (phase_reg == PH_WB0 || phase_reg == PH_WB1 || phase_reg == PH_WB2 ||
                      phase_reg == PH_RB0 || phase_reg == PH_RB1 || phase_reg == PH_RB2)
                     ? cfg.bit_phase_ticks : cfg.hold_ticks;
    assign step_len  = (len_sel == 8'd0) ? 8'd1 : len_sel;
    assign reach     = ({1'b0, tick_count_reg} + 9'd1) >= {1'b0, step_len};
    assign bc_inc    = bit_count_reg + 4'd1;
    assign byte_done = (bc_inc >= BITS_PER_BYTE);

    // Next phase and step decisions
    always_comb begin
        phase_next  = phase_reg;
        do_enter    = 1'b0;
        do_finish   = 1'b0;
        do_reject   = 1'b0;
        do_start    = 1'b0;
        do_timeout  = 1'b0;
        do_wait_inc = 1'b0;
        do_tick_inc = 1'b0;
        do_shift_wr = 1'b0;
        do_shift_rd = 1'b0;
        do_bc_inc   = 1'b0;
        do_bc_clr   = 1'b0;
        if (q_data.is_cmd) begin
            if (phase_reg != PH_IDLE) begin
                do_reject = 1'b1;
            end else begin
                do_start = 1'b1;
                do_enter = 1'b1;
                case (q_data.kind)
                    KIND_START:     phase_next = PH_ST0;
                    KIND_STOP:      phase_next = PH_SP0;
                    KIND_WRITE:     phase_next = PH_WB0;
                    KIND_READ_ACK:  phase_next = PH_AK0;
                    KIND_READ_BYTE: phase_next = PH_RB0;
                    KIND_SEND_ACK:  phase_next = PH_SA0;
                    KIND_PROBE:     phase_next = PH_ST0;
                    default:        phase_next = PH_IDLE;
                endcase
            end
        end else if (phase_reg == PH_AK2) begin
            if (!q_data.sda_level) begin
                if (active_reg == KIND_PROBE) begin
                    phase_next = PH_SP0;
                    do_enter   = 1'b1;
                end else begin
                    do_finish = 1'b1;
                end
            end else if (wait_count_reg >= cfg.ack_wait_limit) begin
                phase_next = PH_SP0;
                do_enter   = 1'b1;
                do_timeout = 1'b1;
            end else begin
                do_wait_inc = 1'b1;
            end
        end else if (phase_reg != PH_IDLE) begin
            do_tick_inc = 1'b1;
            if (reach) begin
                do_enter = 1'b1;
                case (phase_reg)
                    PH_ST0: phase_next = PH_ST1;
                    PH_ST1: begin
                        if (active_reg == KIND_PROBE) begin
                            do_bc_clr  = 1'b1;
                            phase_next = PH_WB0;
                        end else begin
                            do_enter  = 1'b0;
                            do_finish = 1'b1;
                        end
                    end
                    PH_SP0: phase_next = PH_SP1;
                    PH_SP1: phase_next = PH_SP2;
                    PH_WB0: phase_next = PH_WB1;
                    PH_WB1: phase_next = PH_WB2;
                    PH_WB2: begin
                        do_shift_wr = 1'b1;
                        do_bc_inc   = 1'b1;
                        if (!byte_done) begin
                            phase_next = PH_WB0;
                        end else if (active_reg == KIND_PROBE) begin
                            phase_next = PH_AK0;
                        end else begin
                            do_enter  = 1'b0;
                            do_finish = 1'b1;
                        end
                    end
                    PH_AK0: phase_next = PH_AK1;
                    PH_AK1: phase_next = PH_AK2;
                    PH_RB0: phase_next = PH_RB1;
                    PH_RB1: begin
                        do_shift_rd = 1'b1;
                        phase_next  = PH_RB2;
                    end
                    PH_RB2: begin
                        do_bc_inc = 1'b1;
                        if (byte_done) begin
                            do_enter  = 1'b0;
                            do_finish = 1'b1;
                        end else begin
                            phase_next = PH_RB0;
                        end
                    end
                    PH_SA0: phase_next = PH_SA1;
                    PH_SA1: phase_next = PH_SA2;
                    default: begin
                        // stop and send-ack both end on their last phase
                        do_enter  = 1'b0;
                        do_finish = 1'b1;
                    end
                endcase
            end
        end
        if (do_finish) begin
            phase_next = PH_IDLE;
        end
    end

    // Datapath and result
    always_comb begin
        active_next     = active_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        tick_count_next = tick_count_reg;
        wait_count_next = wait_count_reg;
        lines_next      = lines_reg;
        status_next     = status_reg;

        if (do_start) begin
            active_next    = q_data.kind;
            bit_count_next = 4'd0;
            case (q_data.kind)
                KIND_WRITE:     shift_next = q_data.tx_byte;
                KIND_PROBE:     shift_next = q_data.tx_byte;
                KIND_READ_BYTE: shift_next = 8'd0;
                KIND_SEND_ACK:  shift_next = {7'd0, q_data.send_nack};
                default:        shift_next = shift_reg;
            endcase
            if (q_data.kind == KIND_PROBE) begin
                status_next = 2'b00;
            end
        end
        if (do_bc_clr) begin
            bit_count_next = 4'd0;
        end
        if (do_bc_inc) begin
            bit_count_next = bc_inc;
        end
        if (do_shift_wr) begin
            shift_next = {shift_reg[6:0], 1'b0};
        end
        if (do_shift_rd) begin
            shift_next = {shift_reg[6:0], q_data.sda_level};
        end
        if (do_tick_inc) begin
            tick_count_next = tick_count_reg + 8'd1;
        end
        if (do_enter || do_finish) begin
            tick_count_next = 8'd0;
        end
        if (do_wait_inc) begin
            wait_count_next = wait_count_reg + 10'd1;
        end
        if (do_enter && phase_next == PH_AK2) begin
            wait_count_next = 10'd0;
        end
        if (do_enter && phase_next == PH_AK0) begin
            status_next = 2'b00;
        end
        if (do_timeout) begin
            status_next = 2'b11;
        end

        if (do_enter) begin
            lines_next = lines_of(phase_next, shift_next);
        end else if (do_finish && phase_reg == PH_ST1) begin
            lines_next = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
        end else if (do_finish && phase_reg == PH_AK2) begin
            lines_next = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
        end

        m_data_next.scl_level = lines_next.scl;
        m_data_next.sda_out   = lines_next.sda;
        m_data_next.sda_drive = lines_next.drv;
        m_data_next.done_res  = do_finish;
        m_data_next.rx_byte   = (do_finish && active_reg == KIND_READ_BYTE) ? shift_reg : 8'd0;
        m_data_next.got_nack  = status_next[0];
        m_data_next.timed_out = status_next[1];
        m_data_next.rejected  = do_reject;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            active_reg     <= KIND_TICK;
            bit_count_reg  <= 4'd0;
            shift_reg      <= 8'd0;
            tick_count_reg <= 8'd0;
            wait_count_reg <= 10'd0;
            lines_reg      <= '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
            status_reg     <= 2'b00;
            m_valid_reg    <= 1'b0;
        end else begin
            if (fire) begin
                phase_reg      <= phase_next;
                active_reg     <= active_next;
                bit_count_reg  <= bit_count_next;
                shift_reg      <= shift_next;
                tick_count_reg <= tick_count_next;
                wait_count_reg <= wait_count_next;
                lines_reg      <= lines_next;
                status_reg     <= status_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule
